[rtl/crx_pkg.sv]
package crx_pkg;

   // Header: ID byte plus two length bytes.
   localparam int unsigned HeaderBytes = 3;

   // Configuration register indexes.
   localparam logic CsrBufferSize = 1'b0;
   localparam logic CsrFrameId    = 1'b1;

   localparam logic [7:0] FrameIdReset = 8'h41;

   // Receiver lock state, one-hot.
   typedef enum logic [2:0] {
      LOCK_IDLE = 3'b001,
      LOCK_RECV = 3'b010,
      LOCK_HOLD = 3'b100
   } lock_state_type;

   // Encoding seen on the result channel.
   localparam logic [1:0] BufIdle = 2'd0;
   localparam logic [1:0] BufRecv = 2'd1;
   localparam logic [1:0] BufHold = 2'd2;

   typedef struct packed {
      logic        store_valid;
      logic [15:0] store_index;
      logic [7:0]  store_byte;
      logic        frame_done;
      logic        frame_failed;
      logic [15:0] frame_length;
      logic [1:0]  buffer_state;
   } crx_result_type;

   function automatic logic [1:0] lock_code(input lock_state_type st);
      logic [1:0] code;
      code = BufIdle;
      unique case (st)
         LOCK_IDLE: code = BufIdle;
         LOCK_RECV: code = BufRecv;
         LOCK_HOLD: code = BufHold;
         default:   code = BufIdle;
      endcase
      return code;
   endfunction

endpackage

[rtl/crx_deframer.sv]
module crx_deframer
   import crx_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           step_en,
   input  logic           mode,
   input  logic [7:0]     rx_byte,
   input  logic [15:0]    buffer_size,
   input  logic [7:0]     frame_id,
   output crx_result_type result
);

   lock_state_type state_ff, state_in;
   logic [16:0]    pos_ff, pos_in;
   logic [7:0]     len_low_ff, len_low_in;
   logic [15:0]    plen_ff, plen_in;
   logic [7:0]     sum_ff, sum_in;

   logic [16:0]    frame_end;
   logic [15:0]    idx;
   logic           failed;

   assign frame_end = {1'b0, plen_ff} + 17'(HeaderBytes);
   assign idx       = 16'(pos_ff - 17'(HeaderBytes));

   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      len_low_in = len_low_ff;
      plen_in    = plen_ff;
      sum_in     = sum_ff;
      result     = '0;
      failed     = (sum_ff != rx_byte) || (plen_ff > buffer_size);

      if (mode) begin
         // release: drop any frame in flight
         state_in = LOCK_IDLE;
         pos_in   = '0;
         sum_in   = '0;
      end else begin
         unique case (state_ff)
            LOCK_IDLE: begin
               if (rx_byte == frame_id) begin
                  state_in   = LOCK_RECV;
                  pos_in     = 17'd1;
                  len_low_in = '0;
                  plen_in    = '0;
                  sum_in     = '0;
               end
            end
            LOCK_RECV: begin
               priority if (pos_ff == 17'd1) begin
                  len_low_in = rx_byte;
                  pos_in     = 17'd2;
               end else if (pos_ff == 17'd2) begin
                  plen_in = {rx_byte, len_low_ff};
                  pos_in  = 17'd3;
               end else if (pos_ff < frame_end) begin
                  if (idx < buffer_size) begin
                     result.store_valid = 1'b1;
                     result.store_index = idx;
                     result.store_byte  = rx_byte;
                  end
                  sum_in = sum_ff + rx_byte;
                  pos_in = pos_ff + 17'd1;
               end else begin
                  // checksum byte
                  result.frame_done   = 1'b1;
                  result.frame_failed = failed;
                  state_in = failed ? LOCK_IDLE : LOCK_HOLD;
                  pos_in   = '0;
                  sum_in   = '0;
               end
            end
            LOCK_HOLD: begin
            end
            default: begin
               state_in = LOCK_IDLE;
            end
         endcase
      end

      result.frame_length = plen_in;
      result.buffer_state = lock_code(state_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= LOCK_IDLE;
         pos_ff     <= '0;
         len_low_ff <= '0;
         plen_ff    <= '0;
         sum_ff     <= '0;
      end else if (step_en) begin
         state_ff   <= state_in;
         pos_ff     <= pos_in;
         len_low_ff <= len_low_in;
         plen_ff    <= plen_in;
         sum_ff     <= sum_in;
      end
   end

`ifndef ASSERT_OFF
   a_hold_pos_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == LOCK_HOLD |-> pos_ff == '0)
      else $error("position not cleared while holding");

   a_recv_pos_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == LOCK_RECV |-> pos_ff != '0)
      else $error("receiving with zero position");

   a_store_in_range: assert property (@(posedge clock) disable iff (reset)
      step_en && result.store_valid |-> result.store_index < buffer_size)
      else $error("store beyond buffer");

   a_good_frame_holds: assert property (@(posedge clock) disable iff (reset)
      step_en && result.frame_done && !result.frame_failed |=> state_ff == LOCK_HOLD)
      else $error("good frame not held");
`endif

endmodule

[rtl/checksum_frame_receiver_core.sv]
// Checksum frame receiver. Takes one word per accepted req_ item: either a
// received byte (req_mode 0) or a buffer release (req_mode 1). Frames are an ID
// byte matching frame_id, a 16-bit length sent low byte first, the payload,
// and an 8-bit additive checksum of the payload. Each accepted word yields
// exactly one rsp_ word carrying a store strobe and index for payload bytes,
// a done/failed flag on the checksum byte, the announced length and the
// buffer state (0 idle, 1 receiving, 2 holding a good frame). Throughput is
// one word per clock while rsp_ready stays high. rsp_valid rises once the
// accepted req_ word has passed the input register and then the result
// register. While rsp_ready is low the result register holds, and req_ready
// drops once the input register is full as well. Write the CSRs only while
// no word is in flight.
module checksum_frame_receiver_core
   import crx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   // byte / release input
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [7:0]  req_rx_byte,

   // result output
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_store_valid,
   output logic [15:0] rsp_store_index,
   output logic [7:0]  rsp_store_byte,
   output logic        rsp_frame_done,
   output logic        rsp_frame_failed,
   output logic [15:0] rsp_frame_length,
   output logic [1:0]  rsp_buffer_state,

   // CSR write port: index 0 buffer_size, index 1 frame_id
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   // CSRs
   logic [15:0] buffer_size_ff;
   logic [7:0]  frame_id_ff;

   // input register
   logic        in_valid_ff, in_valid_in;
   logic        in_mode_ff;
   logic [7:0]  in_byte_ff;

   // result register
   logic           rsp_valid_ff, rsp_valid_in;
   crx_result_type result_ff, result_in;

   logic advance;   // result register free or being drained
   logic step;      // word moves from input to result register
   logic req_accept;

   assign advance    = !rsp_valid_ff || rsp_ready;
   assign step       = in_valid_ff && advance;
   assign req_ready  = !in_valid_ff || advance;
   assign req_accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_size_ff <= '0;
         frame_id_ff    <= FrameIdReset;
      end else if (csr_write) begin
         unique case (csr_index)
            CsrBufferSize: buffer_size_ff <= csr_wdata;
            CsrFrameId:    frame_id_ff    <= csr_wdata[7:0];
            default:       ;
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_mode_ff <= req_mode;
         in_byte_ff <= req_rx_byte;
      end
      if (step) begin
         result_ff <= result_in;
      end
   end

   // frame state and per-word decode
   crx_deframer u_deframer (
      .clock       (clock),
      .reset       (reset),
      .step_en     (step),
      .mode        (in_mode_ff),
      .rx_byte     (in_byte_ff),
      .buffer_size (buffer_size_ff),
      .frame_id    (frame_id_ff),
      .result      (result_in)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_store_valid  = result_ff.store_valid;
   assign rsp_store_index  = result_ff.store_index;
   assign rsp_store_byte   = result_ff.store_byte;
   assign rsp_frame_done   = result_ff.frame_done;
   assign rsp_frame_failed = result_ff.frame_failed;
   assign rsp_frame_length = result_ff.frame_length;
   assign rsp_buffer_state = result_ff.buffer_state;

`ifndef ASSERT_OFF
   a_step_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("processed word lost");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !step)
      else $error("result overwritten while stalled");

   a_accept_fills_in: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> in_valid_ff)
      else $error("accepted word not staged");
`endif

endmodule

[bench/testbench.sv]
module testbench
   import crx_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   // Hard stop, far above the slowest legal run (about 2300 words).
   localparam int CycleLimit = 300000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid   = 1'b0;
   logic        req_ready;
   logic        req_mode    = 1'b0;
   logic [7:0]  req_rx_byte = 8'h00;

   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   logic        rsp_store_valid;
   logic [15:0] rsp_store_index;
   logic [7:0]  rsp_store_byte;
   logic        rsp_frame_done;
   logic        rsp_frame_failed;
   logic [15:0] rsp_frame_length;
   logic [1:0]  rsp_buffer_state;

   logic        csr_write = 1'b0;
   logic        csr_index = CsrBufferSize;
   logic [15:0] csr_wdata = 16'h0000;

   checksum_frame_receiver_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_store_valid  (rsp_store_valid),
      .rsp_store_index  (rsp_store_index),
      .rsp_store_byte   (rsp_store_byte),
      .rsp_frame_done   (rsp_frame_done),
      .rsp_frame_failed (rsp_frame_failed),
      .rsp_frame_length (rsp_frame_length),
      .rsp_buffer_state (rsp_buffer_state),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #10 clock = ~clock;

   // ------------------------------------------------------------------
   // Deframer shadow: config copy plus receiver state, stepped once per
   // accepted req word. Expected rsp words queue up in rsp_due.
   // ------------------------------------------------------------------
   logic [15:0] cfg_buffer_size = 16'h0000;
   logic [7:0]  cfg_frame_id    = FrameIdReset;

   logic [1:0]  rx_state = BufIdle;
   logic [16:0] rx_pos   = '0;     // 0 = ID byte, 1/2 = length bytes
   logic [7:0]  len_lo   = '0;
   logic [15:0] pay_len  = '0;
   logic [7:0]  run_sum  = '0;

   crx_result_type rsp_due[$];

   int fault_count = 0;
   int words_sent  = 0;
   int cycle_count = 0;

   // Traffic shaping knobs.
   bit req_steady = 1'b0;          // sender never idles
   bit rsp_steady = 1'b0;          // receiver never idles
   int hold_left  = 0;             // receiver hold-off, in cycles

   task automatic deframe_word(input logic mode, input logic [7:0] rx);
      crx_result_type want;
      logic [16:0]    end_pos;
      logic [15:0]    idx;
      want = '0;
      if (mode) begin
         // release: back to idle from anywhere, frame abandoned silently
         rx_state = BufIdle;
         rx_pos   = '0;
         run_sum  = '0;
      end else if (rx_state == BufIdle) begin
         if (rx == cfg_frame_id) begin
            rx_state = BufRecv;
            rx_pos   = 17'd1;
            len_lo   = '0;
            pay_len  = '0;
            run_sum  = '0;
         end
      end else if (rx_state == BufRecv) begin
         end_pos = 17'(pay_len) + 17'(HeaderBytes);
         if (rx_pos == 17'd1) begin
            len_lo = rx;
            rx_pos = 17'd2;
         end else if (rx_pos == 17'd2) begin
            pay_len = {rx, len_lo};
            rx_pos  = 17'd3;
         end else if (rx_pos < end_pos) begin
            idx = 16'(rx_pos - 17'(HeaderBytes));
            // past the buffer end: no store, byte still summed
            if (idx < cfg_buffer_size) begin
               want.store_valid = 1'b1;
               want.store_index = idx;
               want.store_byte  = rx;
            end
            run_sum = run_sum + rx;
            rx_pos  = rx_pos + 17'd1;
         end else begin
            // checksum byte
            want.frame_done   = 1'b1;
            want.frame_failed = (run_sum != rx) || (pay_len > cfg_buffer_size);
            rx_state = want.frame_failed ? BufIdle : BufHold;
            rx_pos   = '0;
            run_sum  = '0;
         end
      end
      // holding + byte: ignored
      want.frame_length = pay_len;
      want.buffer_state = rx_state;
      rsp_due.push_back(want);
   endtask

   // Prediction and checking share one process so that a word accepted
   // and its result in the same step can never race.
   always @(posedge clock) begin
      crx_result_type want;
      crx_result_type got;
      if (!reset) begin
         if (req_valid && req_ready)
            deframe_word(req_mode, req_rx_byte);
         if (rsp_valid && rsp_ready) begin
            got = {rsp_store_valid, rsp_store_index, rsp_store_byte, rsp_frame_done,
                   rsp_frame_failed, rsp_frame_length, rsp_buffer_state};
            if (rsp_due.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("%0t: unexpected rsp word %h", $realtime, got);
            end else begin
               want = rsp_due.pop_front();
               if (got.store_valid !== want.store_valid ||
                   got.store_index !== want.store_index ||
                   got.store_byte !== want.store_byte ||
                   got.frame_done !== want.frame_done ||
                   got.frame_failed !== want.frame_failed ||
                   got.frame_length !== want.frame_length ||
                   got.buffer_state !== want.buffer_state) begin
                  fault_count++;
                  if (fault_count <= 10) begin
                     $display("%0t: rsp mismatch", $realtime);
                     $display("  want sv=%0b idx=%0d byte=%02h done=%0b fail=%0b len=%0d st=%0d",
                              want.store_valid, want.store_index, want.store_byte,
                              want.frame_done, want.frame_failed, want.frame_length,
                              want.buffer_state);
                     $display("  got  sv=%0b idx=%0d byte=%02h done=%0b fail=%0b len=%0d st=%0d",
                              got.store_valid, got.store_index, got.store_byte,
                              got.frame_done, got.frame_failed, got.frame_length,
                              got.buffer_state);
                  end
               end
            end
         end
      end
   end

   // Receiver: random ready, or a counted hold-off when asked for.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (rsp_steady) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= 37);
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Drivers. All of them are entered and left on a rising edge.
   // ------------------------------------------------------------------
   task automatic send_word(input logic mode, input logic [7:0] rx);
      if (!req_steady) begin
         while ($urandom_range(0, 99) < 37) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid   <= 1'b1;
      req_mode    <= mode;
      req_rx_byte <= rx;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      words_sent++;
   endtask

   // Stop offering words and wait for every result to come back.
   task automatic drain_words();
      req_valid <= 1'b0;
      @(posedge clock);
      while (rsp_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [15:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CsrBufferSize: cfg_buffer_size = data;
         CsrFrameId:    cfg_frame_id    = data[7:0];
         default:       ;
      endcase
      @(posedge clock);
   endtask

   // Well-formed frame with random payload; checksum optionally corrupted.
   // With release_after the consumer frees the buffer, sometimes after a
   // few bytes that arrive while the frame is held.
   task automatic send_frame(input logic [15:0] len, input bit sum_ok,
                             input bit release_after);
      logic [7:0] sum;
      logic [7:0] rx;
      int         extra;
      sum = '0;
      send_word(1'b0, cfg_frame_id);
      send_word(1'b0, len[7:0]);
      send_word(1'b0, len[15:8]);
      for (int i = 0; i < int'(len); i++) begin
         rx  = 8'($urandom);
         sum = sum + rx;
         send_word(1'b0, rx);
      end
      if (!sum_ok)
         sum = sum ^ 8'($urandom_range(1, 255));
      send_word(1'b0, sum);
      if (release_after) begin
         extra = $urandom_range(0, 2);
         repeat (extra) send_word(1'b0, 8'($urandom));
         send_word(1'b1, 8'($urandom));
      end
   endtask

   // Mostly short frames, some straddling the buffer end, a few long ones.
   function automatic logic [15:0] pick_length();
      int r;
      int n;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         n = $urandom_range(0, 6);
      end else if (r < 75 && cfg_buffer_size <= 64) begin
         n = int'(cfg_buffer_size) + $urandom_range(0, 2) - 1;
         if (n < 0)
            n = 0;
      end else if (r < 96) begin
         n = $urandom_range(7, 40);
      end else begin
         n = $urandom_range(100, 260);
      end
      return 16'(n);
   endfunction

   task automatic random_traffic(input int words);
      int stop_at;
      int r;
      int n;
      stop_at = words_sent + words;
      while (words_sent < stop_at) begin
         r = $urandom_range(0, 99);
         if (r < 75) begin
            send_frame(pick_length(), $urandom_range(0, 99) < 80,
                       $urandom_range(0, 99) < 90);
         end else if (r < 85) begin
            // abandoned frame: any length, cut short by a release
            send_word(1'b0, cfg_frame_id);
            send_word(1'b0, 8'($urandom));
            send_word(1'b0, 8'($urandom));
            n = $urandom_range(0, 3);
            repeat (n) send_word(1'b0, 8'($urandom));
            send_word(1'b1, 8'($urandom));
         end else if (r < 95) begin
            // line noise, then a release to get back to a known state
            n = $urandom_range(1, 3);
            repeat (n) send_word(1'b0, 8'($urandom));
            send_word(1'b1, 8'($urandom));
         end else begin
            send_word(1'b1, 8'($urandom));
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset config (size 0, ID 'A'), then the corner cases by hand.
   task automatic test_special_cases();
      // non-ID bytes while idle are dropped
      send_word(1'b0, 8'h00);
      send_word(1'b0, 8'hFF);
      // zero-length frame, checksum 0, fits a zero-size buffer -> hold
      send_word(1'b0, FrameIdReset);
      send_word(1'b0, 8'h00);
      send_word(1'b0, 8'h00);
      send_word(1'b0, 8'h00);
      // ID byte while holding is ignored; release with a nonzero byte
      send_word(1'b0, FrameIdReset);
      send_word(1'b1, 8'hFF);
      // one payload byte past a zero-size buffer: no store, frame fails
      send_word(1'b0, FrameIdReset);
      send_word(1'b0, 8'h01);
      send_word(1'b0, 8'h00);
      send_word(1'b0, 8'hFF);
      send_word(1'b0, 8'hFF);
      drain_words();

      // largest buffer, ID 0xFF; upper data bits must not leak into the ID
      write_csr(CsrBufferSize, 16'hFFFF);
      write_csr(CsrFrameId, 16'hA5FF);
      send_word(1'b0, 8'hFF);
      send_word(1'b0, 8'h02);
      send_word(1'b0, 8'h00);
      send_word(1'b0, 8'h80);
      send_word(1'b0, 8'h81);
      send_word(1'b0, 8'h01);     // 0x80 + 0x81 wraps to 0x01
      send_word(1'b1, 8'h00);
      // longest announced length, abandoned mid-payload
      send_word(1'b0, 8'hFF);
      send_word(1'b0, 8'hFF);
      send_word(1'b0, 8'hFF);
      send_word(1'b0, 8'h00);
      send_word(1'b1, 8'h5A);
      drain_words();

      // ID 0x00, bad checksum -> fail, then a release while idle
      write_csr(CsrFrameId, 16'h0000);
      send_word(1'b0, 8'h00);
      send_word(1'b0, 8'h01);
      send_word(1'b0, 8'h00);
      send_word(1'b0, 8'h55);
      send_word(1'b0, 8'h54);
      send_word(1'b1, 8'hA5);
      drain_words();
   endtask

   // Random traffic across several configurations, extremes included.
   task automatic test_random_settings();
      logic [15:0] sizes[7];
      logic [15:0] ids[7];
      sizes = '{16'd0, 16'hFFFF, 16'd8, 16'd1, 16'd5, 16'd32, 16'd0};
      ids   = '{16'h0041, 16'h0000, 16'h00FF, 16'h0000, 16'h0000, 16'h0041, 16'h0000};
      sizes[4] = 16'($urandom_range(0, 20));
      sizes[6] = 16'($urandom);
      ids[3]   = 16'($urandom_range(0, 255));
      ids[4]   = 16'($urandom_range(0, 255));
      ids[6]   = 16'($urandom);
      for (int i = 0; i < 7; i++) begin
         write_csr(CsrBufferSize, sizes[i]);
         write_csr(CsrFrameId, ids[i]);
         random_traffic(200);
         drain_words();
      end
   endtask

   // Long stretch with no idling on either side: one word per clock.
   task automatic test_back_to_back();
      write_csr(CsrBufferSize, 16'd12);
      write_csr(CsrFrameId, 16'h0041);
      req_steady = 1'b1;
      rsp_steady = 1'b1;
      random_traffic(250);
      drain_words();
      req_steady = 1'b0;
      rsp_steady = 1'b0;
   endtask

   // Receiver holds off while the sender keeps pushing: the pipe fills and
   // req_ready must drop without losing or duplicating a word.
   task automatic test_backpressure();
      write_csr(CsrBufferSize, 16'd6);
      write_csr(CsrFrameId, 16'h00C3);
      req_steady = 1'b1;
      hold_left  = 300;
      random_traffic(150);
      req_steady = 1'b0;
      random_traffic(80);
      drain_words();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_special_cases();
      test_random_settings();
      test_back_to_back();
      test_backpressure();

      // settle time past the input and result registers, then the verdict
      repeat (10) @(posedge clock);
      fault_count += rsp_due.size();
      if (fault_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/crx_pkg.sv
rtl/crx_deframer.sv
rtl/checksum_frame_receiver_core.sv
bench/testbench.sv
